### design/rlt_pkg.sv
// shared types, sizes and codes for the request latency table
package rlt_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int TICKS_PER_MS = 10000;
  localparam int REM_W = $clog2(TICKS_PER_MS);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  // divider digit and reciprocal: floor(v / 10000) = (v * TICKS_RECIP) >> RECIP_SHIFT
  // holds exactly for every partial value below 2^PART_W
  localparam int DIG_W = 16;
  localparam int PART_W = REM_W + DIG_W;
  localparam int RECIP_W = 31;
  localparam int RECIP_SHIFT = 44;
  localparam int PROD_W = PART_W + RECIP_W;
  localparam logic [RECIP_W-1:0] TICKS_RECIP = 31'd1759218605;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(1);

  localparam logic CMD_REQUEST  = 1'b0;
  localparam logic CMD_RESPONSE = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH  = 2'd2;

  typedef struct packed {
    logic               command;
    logic [31:0]        connection;
    logic signed [31:0] req_id;
    logic signed [31:0] user_ident;
    logic signed [31:0] app_ident;
    logic signed [31:0] session;
    logic signed [31:0] resp_id;
    logic signed [31:0] list_count;
    logic signed [31:0] worker;
    logic [63:0]        now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_req_id;
    logic signed [31:0] out_user;
    logic signed [31:0] out_app;
    logic signed [31:0] out_session;
    logic signed [31:0] out_resp_id;
    logic signed [31:0] out_list_count;
    logic signed [31:0] out_worker;
    logic [63:0]        start_time;
    logic [63:0]        end_time;
    logic [31:0]        latency_ms;
  } out_item_t;

endpackage

### design/rlt_in_if.sv
// input item channel
interface rlt_in_if import rlt_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/rlt_out_if.sv
// result item channel
interface rlt_out_if import rlt_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/rlt_cfg_if.sv
// configuration write channel
interface rlt_cfg_if import rlt_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

### design/rlt_div.sv
// divider of a 64-bit tick count by the ticks per millisecond, one 16-bit digit per multiply phase and remainder phase
module rlt_div import rlt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  output logic        done,
  output logic [31:0] quotient
);

  logic [63:0]       dvd_r, dvd_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [31:0]       quo_r, quo_nxt;
  logic [DIG_W-1:0]  qd_r, qd_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              phase_r, phase_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PART_W-1:0] part;
  logic [PROD_W-1:0] prod;
  logic [PART_W-1:0] back;

  // per digit: reciprocal multiply for the quotient digit, then remainder
  always_comb begin
    part      = {rem_r, dvd_r[63 -: DIG_W]};
    prod      = PROD_W'(part) * PROD_W'(TICKS_RECIP);
    back      = PART_W'(qd_r) * PART_W'(TICKS_PER_MS);
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    qd_nxt    = qd_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      dvd_nxt   = dividend;
      rem_nxt   = '0;
      quo_nxt   = '0;
      cnt_nxt   = '0;
      phase_nxt = 1'b0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      if (!phase_r) begin
        qd_nxt    = prod[RECIP_SHIFT +: DIG_W];
        phase_nxt = 1'b1;
      end else begin
        rem_nxt   = REM_W'(part - back);
        quo_nxt   = {quo_r[31-DIG_W:0], qd_r};
        dvd_nxt   = {dvd_r[63-DIG_W:0], {DIG_W{1'b0}}};
        cnt_nxt   = cnt_r + 2'd1;
        phase_nxt = 1'b0;
        if (cnt_r == 2'd3) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    qd_r    <= qd_nxt;
    cnt_r   <= cnt_nxt;
    phase_r <= phase_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### design/request_latency_table.sv
// request latency table: outstanding requests keyed by connection, latency on response
//
//   channel | dir | beat
//   in_if   | in  | one request or response item
//   out_if  | out | one result record per response item taken while enabled
//   cfg_if  | in  | register index and write data (enable, limit)
//
// every item taken while enabled scans the 64-entry table one row a cycle.
// a request takes one scan per eviction, one lookup scan and, with a free slot, a store;
// a response takes one scan, then on a same-session match the divider (a multiply step and
// a remainder step per 16-bit digit), and the emit state, which waits on an untaken result.
// reset (synchronous, rst_n low) clears all valid bits and the entry count.
// in_if.ready is high only in idle; a pending result holds until out_if.ready.
module request_latency_table import rlt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rlt_in_if.sink    in_if,
  rlt_out_if.source out_if,
  rlt_cfg_if.sink   cfg_if
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_EVICT = 7'b0000010,
    ST_FIND  = 7'b0000100,
    ST_STORE = 7'b0001000,
    ST_RESP  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic             enable_r;
  logic [6:0]       limit_r;
  logic [CNT_W-1:0] lim;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  in_item_t         item_r;

  // table rows
  logic [31:0] conn_mem [DEPTH];
  logic [63:0] time_mem [DEPTH];
  logic [63:0] ids_mem  [DEPTH];
  logic [63:0] as_mem   [DEPTH];

  // scan pipeline
  logic [IDX_W:0]   scan_r, scan_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic [31:0]      rd_conn_r;
  logic [63:0]      rd_time_r, rd_ids_r, rd_as_r;
  logic             rd_live;
  logic             scan_done;

  // scan results
  logic             hit_vld_r, hit_vld_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [63:0]      hit_time_r, hit_time_nxt;
  logic [31:0]      hit_conn_r, hit_conn_nxt;
  logic [63:0]      hit_ids_r, hit_ids_nxt;
  logic [63:0]      hit_as_r, hit_as_nxt;
  logic             free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  out_item_t res_r, res_nxt;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;

  assign lim = (limit_r == 7'd0) ? CNT_W'(1)
             : ((CNT_W'(limit_r) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(limit_r));

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_vld_r;
  assign out_if.data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      limit_r  <= 7'd64;
    end else if (cfg_if.valid) begin
      if (cfg_if.idx == CFG_ENABLE) begin
        enable_r <= cfg_if.wdata[0];
      end else if (cfg_if.idx == CFG_LIMIT) begin
        limit_r <= cfg_if.wdata[6:0];
      end
    end
  end

  // table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (state_r == ST_STORE && free_vld_r) begin
      conn_mem[free_idx_r] <= item_r.connection;
      time_mem[free_idx_r] <= item_r.now;
      ids_mem[free_idx_r]  <= {item_r.user_ident, item_r.req_id};
      as_mem[free_idx_r]   <= {item_r.session, item_r.app_ident};
    end
    rd_conn_r <= conn_mem[scan_r[IDX_W-1:0]];
    rd_time_r <= time_mem[scan_r[IDX_W-1:0]];
    rd_ids_r  <= ids_mem[scan_r[IDX_W-1:0]];
    rd_as_r   <= as_mem[scan_r[IDX_W-1:0]];
    rd_idx_r  <= scan_r[IDX_W-1:0];
  end

  assign rd_live   = rd_vld_r && valid_r[rd_idx_r];
  assign scan_done = scan_r[IDX_W] && !rd_vld_r;

  rlt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (item_r.now - hit_time_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    count_nxt    = count_r;
    scan_nxt     = scan_r;
    rd_vld_nxt   = 1'b0;
    hit_vld_nxt  = hit_vld_r;
    hit_idx_nxt  = hit_idx_r;
    hit_time_nxt = hit_time_r;
    hit_conn_nxt = hit_conn_r;
    hit_ids_nxt  = hit_ids_r;
    hit_as_nxt   = hit_as_r;
    free_vld_nxt = free_vld_r;
    free_idx_nxt = free_idx_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    div_start    = 1'b0;

    if (out_vld_r && out_if.ready) begin
      out_vld_nxt = 1'b0;
    end

    // address issue while a scan runs
    if ((state_r == ST_EVICT || state_r == ST_FIND || state_r == ST_RESP)
        && !scan_r[IDX_W]) begin
      rd_vld_nxt = 1'b1;
      scan_nxt   = scan_r + (IDX_W+1)'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        scan_nxt    = '0;
        hit_vld_nxt = 1'b0;
        free_vld_nxt = 1'b0;
        if (in_if.valid && enable_r) begin
          if (in_if.data.command == CMD_RESPONSE) begin
            state_nxt = ST_RESP;
          end else if (count_r >= lim) begin
            state_nxt = ST_EVICT;
          end else begin
            state_nxt = ST_FIND;
          end
        end
      end

      ST_EVICT: begin
        // track oldest: smaller time, then smaller connection
        if (rd_live && (!hit_vld_r || rd_time_r < hit_time_r ||
            (rd_time_r == hit_time_r && rd_conn_r < hit_conn_r))) begin
          hit_vld_nxt  = 1'b1;
          hit_idx_nxt  = rd_idx_r;
          hit_time_nxt = rd_time_r;
          hit_conn_nxt = rd_conn_r;
        end
        if (scan_done) begin
          scan_nxt    = '0;
          hit_vld_nxt = 1'b0;
          if (hit_vld_r) begin
            valid_nxt[hit_idx_r] = 1'b0;
            count_nxt = (count_r != '0) ? count_r - CNT_W'(1) : count_r;
            state_nxt = (count_nxt >= lim) ? ST_EVICT : ST_FIND;
          end else begin
            count_nxt = '0;
            state_nxt = ST_FIND;
          end
        end
      end

      ST_FIND: begin
        // same connection is dropped, so its slot counts as free too
        if (rd_live && rd_conn_r == item_r.connection && !hit_vld_r) begin
          hit_vld_nxt = 1'b1;
          hit_idx_nxt = rd_idx_r;
        end
        if (rd_vld_r && !free_vld_r &&
            (!valid_r[rd_idx_r] || rd_conn_r == item_r.connection)) begin
          free_vld_nxt = 1'b1;
          free_idx_nxt = rd_idx_r;
        end
        if (scan_done) begin
          if (hit_vld_r) begin
            valid_nxt[hit_idx_r] = 1'b0;
            count_nxt = (count_r != '0) ? count_r - CNT_W'(1) : count_r;
          end
          state_nxt = free_vld_r ? ST_STORE : ST_IDLE;
        end
      end

      ST_STORE: begin
        valid_nxt[free_idx_r] = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ST_IDLE;
      end

      ST_RESP: begin
        if (rd_live && rd_conn_r == item_r.connection && !hit_vld_r) begin
          hit_vld_nxt  = 1'b1;
          hit_idx_nxt  = rd_idx_r;
          hit_time_nxt = rd_time_r;
          hit_ids_nxt  = rd_ids_r;
          hit_as_nxt   = rd_as_r;
        end
        if (scan_done) begin
          res_nxt = '0;
          if (!hit_vld_r) begin
            res_nxt.status = STATUS_NOT_FOUND;
            state_nxt = ST_EMIT;
          end else begin
            valid_nxt[hit_idx_r] = 1'b0;
            count_nxt = (count_r != '0) ? count_r - CNT_W'(1) : count_r;
            if (hit_as_r[63:32] != item_r.session) begin
              res_nxt.status = STATUS_MISMATCH;
              state_nxt = ST_EMIT;
            end else begin
              res_nxt.status         = STATUS_OK;
              res_nxt.out_req_id     = hit_ids_r[31:0];
              res_nxt.out_user       = hit_ids_r[63:32];
              res_nxt.out_app        = hit_as_r[31:0];
              res_nxt.out_session    = hit_as_r[63:32];
              res_nxt.out_resp_id    = item_r.resp_id;
              res_nxt.out_list_count = item_r.list_count;
              res_nxt.out_worker     = item_r.worker;
              res_nxt.start_time     = hit_time_r;
              res_nxt.end_time       = item_r.now;
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          res_nxt.latency_ms = div_quo;
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_vld_r || out_if.ready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = res_r;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      scan_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      rd_vld_r  <= rd_vld_nxt;
      scan_r    <= scan_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r <= in_if.data;
    end
    hit_vld_r  <= hit_vld_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_time_r <= hit_time_nxt;
    hit_conn_r <= hit_conn_nxt;
    hit_ids_r  <= hit_ids_nxt;
    hit_as_r   <= hit_as_nxt;
    free_vld_r <= free_vld_nxt;
    free_idx_r <= free_idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### bench/tb.sv
// testbench for the request latency table: queue-fed driver, monitor, scoreboard
module tb;
  import rlt_pkg::*;

  logic clk;
  logic rst_n;

  rlt_in_if  in_ch ();
  rlt_out_if out_ch ();
  rlt_cfg_if cfg_ch ();

  request_latency_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  localparam int CYCLE_LIMIT = 2000000;

  // shadow of the table and the registers
  logic        tbl_valid [DEPTH];
  logic [31:0] tbl_conn [DEPTH];
  logic [63:0] tbl_time [DEPTH];
  logic [31:0] tbl_req [DEPTH];
  logic [31:0] tbl_user [DEPTH];
  logic [31:0] tbl_app [DEPTH];
  logic [31:0] tbl_sess [DEPTH];
  int          tbl_count;
  logic        shadow_enable;
  logic [6:0]  shadow_limit;

  in_item_t  pending_items[$];
  out_item_t expected_records[$];
  int        fail_count;
  int        cycle_count;
  int        hold_off;
  bit        stall_pattern;
  int        burst_left;
  int        gap_left;
  bit        in_acc;
  logic [31:0] conn_pool [8];

  function automatic int find_conn(logic [31:0] c);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i] && tbl_conn[i] == c) return i;
    return -1;
  endfunction

  function automatic int find_oldest();
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!tbl_valid[i]) continue;
      if (best < 0 || tbl_time[i] < tbl_time[best] ||
          (tbl_time[i] == tbl_time[best] && tbl_conn[i] < tbl_conn[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic void drop_row(int i);
    tbl_valid[i] = 1'b0;
    if (tbl_count > 0) tbl_count--;
  endfunction

  // work out the record a beat causes, if any
  function automatic void predict_latency(in_item_t it);
    int        lim;
    int        i;
    out_item_t r;
    logic [63:0] diff;
    if (!shadow_enable) return;
    if (it.command == CMD_REQUEST) begin
      lim = int'(shadow_limit);
      if (lim < 1) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      while (tbl_count >= lim) begin
        i = find_oldest();
        if (i < 0) begin
          tbl_count = 0;
          break;
        end
        drop_row(i);
      end
      i = find_conn(it.connection);
      if (i >= 0) drop_row(i);
      for (i = 0; i < DEPTH; i++)
        if (!tbl_valid[i]) break;
      if (i >= DEPTH) return;
      tbl_valid[i] = 1'b1;
      tbl_conn[i]  = it.connection;
      tbl_time[i]  = it.now;
      tbl_req[i]   = it.req_id;
      tbl_user[i]  = it.user_ident;
      tbl_app[i]   = it.app_ident;
      tbl_sess[i]  = it.session;
      tbl_count++;
      return;
    end
    r = '0;
    i = find_conn(it.connection);
    if (i < 0) begin
      r.status = STATUS_NOT_FOUND;
    end else begin
      drop_row(i);
      if (tbl_sess[i] != it.session) begin
        r.status = STATUS_MISMATCH;
      end else begin
        diff = it.now - tbl_time[i];
        r.status         = STATUS_OK;
        r.out_req_id     = tbl_req[i];
        r.out_user       = tbl_user[i];
        r.out_app        = tbl_app[i];
        r.out_session    = tbl_sess[i];
        r.out_resp_id    = it.resp_id;
        r.out_list_count = it.list_count;
        r.out_worker     = it.worker;
        r.start_time     = tbl_time[i];
        r.end_time       = it.now;
        r.latency_ms     = 32'(diff / 64'd10000);
      end
    end
    expected_records.push_back(r);
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 3))
      0: rand32 = 32'h0000_0000;
      1: rand32 = 32'hFFFF_FFFF;
      default: rand32 = $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(logic cmd, logic [31:0] conn, logic [31:0] sess,
                                         logic [63:0] ts);
    in_item_t it;
    it.command    = cmd;
    it.connection = conn;
    it.req_id     = rand32();
    it.user_ident = rand32();
    it.app_ident  = rand32();
    it.session    = sess;
    it.resp_id    = rand32();
    it.list_count = rand32();
    it.worker     = rand32();
    it.now        = ts;
    return it;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // input accept at the rising edge: predict and retire the beat
  always @(posedge clk) begin
    in_acc = rst_n && in_ch.valid && in_ch.ready;
    if (in_acc) begin
      predict_latency(in_ch.data);
      void'(pending_items.pop_front());
    end
  end

  // input driver: bursts and gaps, changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_acc) begin
      // beat still waiting, hold it
    end else if (gap_left > 0) begin
      gap_left--;
      in_ch.valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      in_ch.valid <= 1'b1;
      in_ch.data  <= pending_items[0];
      if (burst_left > 0) burst_left--;
      else begin
        burst_left = $urandom_range(0, 12);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // receiver stall pattern, with a long hold-off when asked
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_ch.ready <= 1'b0;
    end else if (stall_pattern) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // record monitor
  always @(posedge clk) begin
    out_item_t e;
    out_item_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (expected_records.size() == 0) begin
        $error("record with nothing expected: %p", a);
        fail_count++;
      end else begin
        e = expected_records.pop_front();
        if (a.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, a.status); fail_count++;
        end
        if (a.out_req_id !== e.out_req_id) begin
          $error("out_req_id exp %0d got %0d", e.out_req_id, a.out_req_id); fail_count++;
        end
        if (a.out_user !== e.out_user) begin
          $error("out_user exp %0d got %0d", e.out_user, a.out_user); fail_count++;
        end
        if (a.out_app !== e.out_app) begin
          $error("out_app exp %0d got %0d", e.out_app, a.out_app); fail_count++;
        end
        if (a.out_session !== e.out_session) begin
          $error("out_session exp %0d got %0d", e.out_session, a.out_session); fail_count++;
        end
        if (a.out_resp_id !== e.out_resp_id) begin
          $error("out_resp_id exp %0d got %0d", e.out_resp_id, a.out_resp_id); fail_count++;
        end
        if (a.out_list_count !== e.out_list_count) begin
          $error("out_list_count exp %0d got %0d", e.out_list_count, a.out_list_count);
          fail_count++;
        end
        if (a.out_worker !== e.out_worker) begin
          $error("out_worker exp %0d got %0d", e.out_worker, a.out_worker); fail_count++;
        end
        if (a.start_time !== e.start_time) begin
          $error("start_time exp %0h got %0h", e.start_time, a.start_time); fail_count++;
        end
        if (a.end_time !== e.end_time) begin
          $error("end_time exp %0h got %0h", e.end_time, a.end_time); fail_count++;
        end
        if (a.latency_ms !== e.latency_ms) begin
          $error("latency_ms exp %0d got %0d", e.latency_ms, a.latency_ms); fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // one register write, only while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_ENABLE) shadow_enable = val[0];
    else if (idx == CFG_LIMIT) shadow_limit = val[6:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for all beats accepted and records drained, then a quiet stretch
  task automatic drain();
    while (pending_items.size() > 0 || expected_records.size() > 0) @(posedge clk);
    repeat (200 * DEPTH) @(posedge clk);
  endtask

  // random phase: request/response items on a small pool, random ones when wild
  task automatic random_phase(int n, int pool_n, bit wild);
    logic [63:0] ts;
    logic [31:0] sess [8];
    int          k;
    ts = {$urandom, $urandom};
    for (int j = 0; j < 8; j++) sess[j] = rand32();
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(0, pool_n - 1);
      ts = ts + $urandom_range(0, 200000);
      if (wild && $urandom_range(0, 9) == 0)
        pending_items.push_back(make_item(1'($urandom_range(0, 1)), rand32(), rand32(),
                                          {$urandom, $urandom}));
      else if ($urandom_range(0, 1) == 0)
        pending_items.push_back(make_item(CMD_REQUEST, conn_pool[k], sess[k],
                                          ($urandom_range(0, 7) == 0) ? ts - 5 : ts));
      else
        pending_items.push_back(make_item(CMD_RESPONSE, conn_pool[k],
                                          ($urandom_range(0, 7) == 0) ? ~sess[k] : sess[k], ts));
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx   = CFG_ENABLE;
    cfg_ch.wdata = '0;
    rst_n = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    hold_off = 0;
    stall_pattern = 1'b0;
    burst_left = 0;
    gap_left = 0;
    in_acc = 1'b0;
    shadow_enable = 1'b0;
    shadow_limit = 7'd64;
    tbl_count = 0;
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < 8; i++) conn_pool[i] = rand32();
    conn_pool[0] = 32'h0;
    conn_pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // disabled: everything ignored
    pending_items.push_back(make_item(CMD_REQUEST, 32'h5, 32'h1, 64'd100));
    pending_items.push_back(make_item(CMD_RESPONSE, 32'h5, 32'h1, 64'd200));
    drain();

    // directed: extremes, mismatch, not found, ties, time going backwards
    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_LIMIT, 32'd64);
    pending_items.push_back(make_item(CMD_REQUEST, 32'h0, 32'h8000_0000, 64'h0));
    pending_items.push_back(make_item(CMD_REQUEST, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                      64'hFFFF_FFFF_FFFF_FFFF));
    pending_items.push_back(make_item(CMD_RESPONSE, 32'h0, 32'h8000_0000,
                                      64'hFFFF_FFFF_FFFF_FFFF));
    pending_items.push_back(make_item(CMD_RESPONSE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 64'd10));
    pending_items.push_back(make_item(CMD_RESPONSE, 32'h1234, 32'h0, 64'd10));
    pending_items.push_back(make_item(CMD_REQUEST, 32'h7, 32'h3, 64'd50));
    pending_items.push_back(make_item(CMD_REQUEST, 32'h7, 32'h4, 64'd60));
    pending_items.push_back(make_item(CMD_RESPONSE, 32'h7, 32'h3, 64'd70));
    pending_items.push_back(make_item(CMD_REQUEST, 32'h9, 32'h1, 64'd5));
    pending_items.push_back(make_item(CMD_REQUEST, 32'h8, 32'h1, 64'd5));
    pending_items.push_back(make_item(CMD_REQUEST, 32'h6, 32'h1, 64'd9));
    drain();
    // lowered limit evicts oldest with ties to the smaller connection
    write_reg(CFG_LIMIT, 32'd1);
    pending_items.push_back(make_item(CMD_REQUEST, 32'hA, 32'h1, 64'd99));
    pending_items.push_back(make_item(CMD_RESPONSE, 32'h8, 32'h1, 64'd100));
    pending_items.push_back(make_item(CMD_RESPONSE, 32'hA, 32'h1, 64'd30099));
    drain();
    write_reg(CFG_LIMIT, 32'd0);
    pending_items.push_back(make_item(CMD_REQUEST, 32'hB, 32'h2, 64'd1));
    pending_items.push_back(make_item(CMD_REQUEST, 32'hC, 32'h2, 64'd2));
    pending_items.push_back(make_item(CMD_RESPONSE, 32'hB, 32'h2, 64'd3));
    pending_items.push_back(make_item(CMD_RESPONSE, 32'hC, 32'h2, 64'd3));
    drain();

    // random phases over several settings; long receiver hold-off in one
    write_reg(CFG_LIMIT, 32'd127);
    stall_pattern = 1'b1;
    random_phase(250, 8, 1'b1);
    drain();
    write_reg(CFG_LIMIT, 32'd3);
    hold_off = 3000;
    random_phase(250, 8, 1'b0);
    drain();
    write_reg(CFG_LIMIT, 32'd64);
    stall_pattern = 1'b0;
    random_phase(250, 8, 1'b1);
    drain();
    write_reg(CFG_LIMIT, 32'd2);
    stall_pattern = 1'b1;
    random_phase(250, 4, 1'b1);
    drain();
    write_reg(CFG_ENABLE, 32'd0);
    random_phase(20, 4, 1'b0);
    drain();

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

### sim.f
design/rlt_pkg.sv
design/rlt_in_if.sv
design/rlt_out_if.sv
design/rlt_cfg_if.sv
design/rlt_div.sv
design/request_latency_table.sv
bench/tb.sv
